// File: hdl/esc_pkg.sv
package esc_pkg;

	localparam int unsigned EPOCH_YEAR  = 1970;
	localparam int unsigned YEAR_COUNT  = 138;
	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN = 60;

	// reciprocal constants; all but YEAR_RECIP are exact over the value range they see
	localparam logic [25:0] DAY_RECIP   = 26'd50903317; // 2^35 / 675, on secs >> 7
	localparam int unsigned DAY_SHIFT   = 35;
	localparam logic [13:0] YEAR_RECIP  = 14'd11491;    // 2^22 / 365, rounded down
	localparam logic [15:0] HOUR_RECIP  = 16'd37283;    // 2^27 / 3600
	localparam logic [12:0] MIN_RECIP   = 13'd4370;     // 2^18 / 60

	typedef logic [15:0] ystart_arr_t [0:YEAR_COUNT-1];
	typedef logic [YEAR_COUNT-1:0] leap_vec_t;

	function automatic logic year_is_leap(input int unsigned y);
		return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
	endfunction

	// day number of 1 January of each year, counted from the epoch
	function automatic ystart_arr_t build_year_start();
		ystart_arr_t acc;
		int unsigned d;
		d = 0;
		for (int unsigned i = 0; i < YEAR_COUNT; i++) begin
			acc[i] = 16'(d);
			d = d + (year_is_leap(EPOCH_YEAR + i) ? 366 : 365);
		end
		return acc;
	endfunction

	function automatic leap_vec_t build_leap();
		leap_vec_t v;
		for (int unsigned i = 0; i < YEAR_COUNT; i++) begin
			v[i] = year_is_leap(EPOCH_YEAR + i);
		end
		return v;
	endfunction

	localparam ystart_arr_t YEAR_START = build_year_start();
	localparam leap_vec_t   YEAR_LEAP  = build_leap();

	// day of year at which month m+1 begins, m counted from 0
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd0:  base = 9'd0;
			4'd1:  base = 9'd31;
			4'd2:  base = 9'd59;
			4'd3:  base = 9'd90;
			4'd4:  base = 9'd120;
			4'd5:  base = 9'd151;
			4'd6:  base = 9'd181;
			4'd7:  base = 9'd212;
			4'd8:  base = 9'd243;
			4'd9:  base = 9'd273;
			4'd10: base = 9'd304;
			4'd11: base = 9'd334;
			default: base = 9'd0;
		endcase
		return (leap && (m >= 4'd2)) ? base + 9'd1 : base;
	endfunction

endpackage

// File: hdl/epoch_seconds_to_calendar.sv
// Channel   Handshake          Payload
// --------  -----------------  ----------------------------------------
// input     start / busy       epoch_seconds
// result    done (strobe)      year, month, day, hour, minute, second
//
// Six register stages; an item may start in every cycle and its result
// strobes on done when it leaves the last stage.
// busy never rises: the pipeline has no stall path; the receiver must take
// every result in the cycle it is shown, which the block does not enforce.
// arst_n clears the valid bits only; payload stages carry no reset.
module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	// valid bits travel alongside the data
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage 1: whole days by reciprocal multiply
	logic [31:0] secs_s1;
	logic [50:0] dprod_s1;

	// stage 2: days and time of day
	logic [15:0] days_s2;
	logic [16:0] tod_s2;

	// stage 3: year estimate and hour
	logic [15:0] days_s3;
	logic [7:0]  yest_s3;
	logic [16:0] tod_s3;
	logic [4:0]  hour_s3;

	// stage 4: year fixed, day of year, seconds within the hour
	logic [11:0] year_s4;
	logic [8:0]  yday_s4;
	logic        leap_s4;
	logic [11:0] rem_s4;
	logic [4:0]  hour_s4;

	// stage 5: month, day, minute
	logic [11:0] year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  minute_s5;
	logic [11:0] rem_s5;

	// stage 6: second, output register
	logic [11:0] year_s6;
	logic [3:0]  month_s6;
	logic [4:0]  day_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;
	logic [5:0]  second_s6;

	logic        take;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// ---- stage 1: 86400 = 128 * 675, so shift then multiply by 1/675
	always_ff @(posedge clk) begin
		secs_s1  <= epoch_seconds;
		dprod_s1 <= epoch_seconds[31:7] * esc_pkg::DAY_RECIP;
	end

	// ---- stage 2: remainder of the day by back-multiply
	logic [15:0] days_c2;
	logic [32:0] dback_c2;
	logic [31:0] todw_c2;

	always_comb begin
		days_c2  = dprod_s1[esc_pkg::DAY_SHIFT +: 16];
		dback_c2 = days_c2 * 17'(esc_pkg::SECS_PER_DAY);
		todw_c2  = secs_s1 - dback_c2[31:0];
	end

	always_ff @(posedge clk) begin
		days_s2 <= days_c2;
		tod_s2  <= todw_c2[16:0];
	end

	// ---- stage 3: days / 365 (may be off by one either way) and tod / 3600
	logic [29:0] yprod_c3;
	logic [32:0] hprod_c3;

	always_comb begin
		yprod_c3 = days_s2 * esc_pkg::YEAR_RECIP;
		hprod_c3 = tod_s2 * esc_pkg::HOUR_RECIP;
	end

	always_ff @(posedge clk) begin
		days_s3 <= days_s2;
		yest_s3 <= yprod_c3[29:22];
		tod_s3  <= tod_s2;
		hour_s3 <= hprod_c3[31:27];
	end

	// ---- stage 4: the true year index lies within one of the estimate;
	// read three year starts from the constant table and pick
	logic [7:0]  ilo_c4, ihi_c4, idx_c4;
	logic [15:0] slo_c4, smid_c4, shi_c4, ysel_c4;
	logic [15:0] ydayw_c4;
	logic [16:0] hback_c4;
	logic [16:0] remw_c4;

	always_comb begin
		ilo_c4  = (yest_s3 == 8'd0) ? 8'd0 : yest_s3 - 8'd1;
		ihi_c4  = yest_s3 + 8'd1;
		slo_c4  = esc_pkg::YEAR_START[ilo_c4];
		smid_c4 = esc_pkg::YEAR_START[yest_s3];
		shi_c4  = esc_pkg::YEAR_START[ihi_c4];
		if (days_s3 < smid_c4) begin
			idx_c4  = ilo_c4;
			ysel_c4 = slo_c4;
		end else if (days_s3 >= shi_c4) begin
			idx_c4  = ihi_c4;
			ysel_c4 = shi_c4;
		end else begin
			idx_c4  = yest_s3;
			ysel_c4 = smid_c4;
		end
		ydayw_c4 = days_s3 - ysel_c4;
		hback_c4 = 17'(hour_s3) * 17'(esc_pkg::SECS_PER_HOUR);
		remw_c4  = tod_s3 - hback_c4;
	end

	always_ff @(posedge clk) begin
		year_s4 <= 12'(esc_pkg::EPOCH_YEAR) + {4'd0, idx_c4};
		yday_s4 <= ydayw_c4[8:0];
		leap_s4 <= esc_pkg::YEAR_LEAP[idx_c4];
		rem_s4  <= remw_c4[11:0];
		hour_s4 <= hour_s3;
	end

	// ---- stage 5: month by parallel compares against month starts
	logic [3:0]  mon_c5;
	logic [8:0]  mday_c5;
	logic [24:0] mprod_c5;

	always_comb begin
		mon_c5 = 4'd1;
		for (int m = 1; m < 12; m++) begin
			if (yday_s4 >= esc_pkg::month_start(4'(m), leap_s4)) begin
				mon_c5 = 4'(m + 1);
			end
		end
		mday_c5  = yday_s4 - esc_pkg::month_start(mon_c5 - 4'd1, leap_s4) + 9'd1;
		mprod_c5 = rem_s4 * esc_pkg::MIN_RECIP;
	end

	always_ff @(posedge clk) begin
		year_s5   <= year_s4;
		month_s5  <= mon_c5;
		day_s5    <= mday_c5[4:0];
		hour_s5   <= hour_s4;
		minute_s5 <= mprod_c5[23:18];
		rem_s5    <= rem_s4;
	end

	// ---- stage 6: second by back-multiply of the minute
	logic [11:0] sback_c6;
	logic [11:0] secw_c6;

	always_comb begin
		sback_c6 = 12'(minute_s5) * 12'(esc_pkg::SECS_PER_MIN);
		secw_c6  = rem_s5 - sback_c6;
	end

	always_ff @(posedge clk) begin
		year_s6   <= year_s5;
		month_s6  <= month_s5;
		day_s6    <= day_s5;
		hour_s6   <= hour_s5;
		minute_s6 <= minute_s5;
		second_s6 <= secw_c6[5:0];
	end

	assign done   = vld_s6;
	assign year   = year_s6;
	assign month  = month_s6;
	assign day    = day_s6;
	assign hour   = hour_s6;
	assign minute = minute_s6;
	assign second = second_s6;

	// every item taken strobes out on done when it leaves the last stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##6 done)
		else $error("item lost in pipeline");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 6))
		else $error("result without item");

	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1))
		else $error("month or day out of range");

	a_clock: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
		else $error("time of day out of range");

endmodule

// File: tb/tb_top.sv
module tb_top;

	// One calendar breakdown of a timestamp.
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_t;

	// Directed stimulus row; has_cal marks rows whose calendar is typed in.
	typedef struct {
		logic [31:0] secs;
		bit          has_cal;
		cal_t        cal;
	} row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] epoch_seconds;
	logic        done;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	cal_t pending_cal[$];
	int   mismatches;
	int   items_sent;
	int   dates_checked;
	int   idle_cycles;
	int   send_gap_pct;
	bit   timed_out;

	epoch_seconds_to_calendar dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.epoch_seconds(epoch_seconds),
		.done(done),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gregorian rule: every fourth year, skip centuries unless divisible by 400.
	function automatic bit is_gregorian_leap(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	// Break a timestamp into date and time of day.
	function automatic cal_t to_calendar(input logic [31:0] secs);
		cal_t c;
		int unsigned days, tod, y, m, mlen;
		int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		days = secs / 86400;
		tod  = secs % 86400;
		y    = 1970;
		// strip whole years
		while (days >= (is_gregorian_leap(y) ? 366 : 365)) begin
			days -= is_gregorian_leap(y) ? 366 : 365;
			y++;
		end
		// then whole months; December takes whatever is left
		for (m = 0; m < 11; m++) begin
			mlen = mdays[m] + ((m == 1 && is_gregorian_leap(y)) ? 1 : 0);
			if (days < mlen)
				break;
			days -= mlen;
		end
		c.year   = 12'(y);
		c.month  = 4'(m + 1);
		c.day    = 5'(days + 1);
		c.hour   = 5'(tod / 3600);
		c.minute = 6'((tod / 60) % 60);
		c.second = 6'(tod % 60);
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %0s: got %0d, expected %0d (date %0d)", what, got, want,
			dates_checked);
		mismatches++;
	endtask

	// Compare each strobed result with the oldest expected calendar.
	always @(posedge clk) begin
		cal_t want;
		if (arst_n && done) begin
			if (pending_cal.size() == 0) begin
				$display("MISMATCH unexpected result %0d-%0d-%0d", year, month, day);
				mismatches++;
			end else begin
				want = pending_cal.pop_front();
				if (year !== want.year)     report_mismatch("year", year, want.year);
				if (month !== want.month)   report_mismatch("month", month, want.month);
				if (day !== want.day)       report_mismatch("day", day, want.day);
				if (hour !== want.hour)     report_mismatch("hour", hour, want.hour);
				if (minute !== want.minute) report_mismatch("minute", minute, want.minute);
				if (second !== want.second) report_mismatch("second", second, want.second);
				dates_checked++;
			end
		end
	end

	// Count cycles with nothing accepted on either side; give up at the limit.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		timed_out = 1'b1;
		$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Offer one item, after an optional random gap, and hold it until it is taken.
	// Start stays high from one item to the next when there is no gap.
	task automatic send_item(input logic [31:0] secs, input cal_t want);
		if ($urandom_range(99, 0) < send_gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start         <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_cal.push_back(want);
		items_sent++;
	endtask

	// Pick a timestamp: mostly uniform, some near the range ends and around midnight.
	function automatic logic [31:0] random_secs();
		int unsigned pick;
		int unsigned d;
		pick = $urandom_range(9, 0);
		case (pick)
			0: return 32'hFFFF_FFFF - $urandom_range(200000, 0);
			1: return $urandom_range(200000, 0);
			2, 3: begin
				// just around midnight of a random day
				d = $urandom_range(49709, 1);
				return 32'(d * 86400 + $urandom_range(2, 0)) - 32'd1;
			end
			default: return $urandom();
		endcase
	endfunction

	initial begin
		row_t rows[$];
		cal_t c;
		int   phase;
		row_t r;

		start         = 1'b0;
		epoch_seconds = '0;
		arst_n        = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		dates_checked = 0;
		send_gap_pct  = 0;
		timed_out     = 1'b0;

		// Epoch start, all-ones, last second of day one and of 1970; later each input bit alone.
		rows.push_back('{32'd0, 1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}});
		rows.push_back('{32'hFFFF_FFFF, 1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}});
		rows.push_back('{32'd86399, 1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}});
		rows.push_back('{32'd31535999, 1'b1, '{12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}});
		// leap century: 2000-02-29 and the day after
		rows.push_back('{32'd951782400, 1'b1, '{12'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}});
		rows.push_back('{32'd951868800, 1'b1, '{12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}});
		// non-leap century: 2100-02-28 then 2100-03-01
		rows.push_back('{32'd4107456000, 1'b1, '{12'd2100, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0}});
		rows.push_back('{32'd4107542400, 1'b1, '{12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}});
		rows.push_back('{32'h5555_5555, 1'b0, '0});
		rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
		rows.push_back('{32'd68169599, 1'b0, '0});
		rows.push_back('{32'd946684799, 1'b0, '0});
		for (int b = 0; b < 32; b++)
			rows.push_back('{32'd1 << b, 1'b0, '0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: typed-in calendars where given, predictor elsewhere.
		foreach (rows[i]) begin
			r = rows[i];
			c = r.has_cal ? r.cal : to_calendar(r.secs);
			send_item(r.secs, c);
		end

		// Random phases: back to back, sparse sender, rare gaps, then mixed gaps.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       send_gap_pct = 0;
				1:       send_gap_pct = 88;
				2:       send_gap_pct = 9;
				default: send_gap_pct = 50;
			endcase
			repeat (160) begin
				r.secs = random_secs();
				send_item(r.secs, to_calendar(r.secs));
			end
		end
		start <= 1'b0;

		// Drain the pipeline, then idle for DRAIN_CYCLES to catch stray strobes.
		while (pending_cal.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d timestamps across the whole 32-bit range,", items_sent);
		$display("century leap rules and day edges; %0d results checked.", dates_checked);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
hdl/esc_pkg.sv
hdl/epoch_seconds_to_calendar.sv
tb/tb_top.sv
